FILE: design/heap_sort_engine_core_macros.svh
// assertion macros shared by the heap sort engine rtl
`ifndef HEAP_SORT_ENGINE_CORE_MACROS_SVH
`define HEAP_SORT_ENGINE_CORE_MACROS_SVH

// condition must hold at every clock edge outside reset
`define HSE_CHECK(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
	else $error("heap sort engine check failed");

// consequent must hold in the same cycle as the antecedent
`define HSE_CHECK_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("heap sort engine check failed");

`endif

FILE: design/hse_pkg.sv
// shared constants and types for the heap sort engine
package hse_pkg;

	localparam int DATA_W    = 32;
	localparam int DEPTH_DEF = 64;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_BLD_RD,
		ST_BLD_LD,
		ST_EXT_RD,
		ST_EXT_LD,
		ST_SIFT_RD,
		ST_SIFT_CMP,
		ST_EMIT
	} state_t;

endpackage

FILE: design/heap_sort_engine_core.sv
// heap sort engine: loads a set of signed values, heap sorts it in place, streams it out
//
// Input channel (item_valid / item_stall, value, last): one value per beat, one beat
// per cycle while loading. The beat with last set closes the set. Values past the
// store depth are dropped and every result of that set carries overflow.
// After the closing beat item_stall stays high while the set is sorted: a build pass
// sifts down every non-leaf node, then the root is swapped out for every element but
// the last and the new root sifted down. Each sift level (the stopping one included)
// passes a child read state and a compare and write back state; each build node and
// each extraction adds a read and a load state of its own.
// Results (result_valid / result_stall, sorted_value, final_res, overflow) then leave
// in ascending order, one store read in flight at a time; final_res marks the last one.
// A stalled result holds in the output register. Once the last entry has been read
// from the store the block takes new input beats, even while that result still waits.
// Reset clears the control state and the element count; the store needs no clearing.
`include "heap_sort_engine_core_macros.svh"

module heap_sort_engine_core #(
	parameter int DEPTH = hse_pkg::DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic signed [31:0] value,
	input  logic               last,
	output logic               result_valid,
	input  logic               result_stall,
	output logic signed [31:0] sorted_value,
	output logic               final_res,
	output logic               overflow
);

	localparam int AW  = $clog2(DEPTH);
	localparam int CW  = $clog2(DEPTH + 1);
	localparam int CHW = AW + 2;

	hse_pkg::state_t state_q, state_d;

	logic [CW-1:0]  cnt_q;
	logic           drop_q;
	logic [CW-1:0]  k_q;
	logic [CW-1:0]  size_q;
	logic [AW-1:0]  node_q;
	logic           bld_q;
	logic [CW-1:0]  idx_q;
	logic           pend_q;
	logic           fin_s1;
	logic signed [hse_pkg::DATA_W-1:0] cur_q;

	logic           res_valid_q;
	logic signed [hse_pkg::DATA_W-1:0] res_value_q;
	logic           res_final_q;
	logic           res_ovf_q;

	logic                       we;
	logic [AW-1:0]              waddr;
	logic [hse_pkg::DATA_W-1:0] wdata;
	logic [AW-1:0]              raddr_a;
	logic [AW-1:0]              raddr_b;
	logic [hse_pkg::DATA_W-1:0] rdata_a;
	logic [hse_pkg::DATA_W-1:0] rdata_b;

	logic           room;
	logic [CW-1:0]  n_next;
	logic [CW-1:0]  half;
	logic [CW-1:0]  k_dec;
	logic [CHW-1:0] left_w;
	logic [CHW-1:0] right_w;
	logic           l_in;
	logic           r_in;
	logic signed [hse_pkg::DATA_W-1:0] rd_l;
	logic signed [hse_pkg::DATA_W-1:0] rd_r;
	logic signed [hse_pkg::DATA_W-1:0] best;
	logic           sel_l;
	logic           sel_r;
	logic           emit_go;
	logic           emit_end;

	hse_ram #(.DEPTH(DEPTH)) u_ram (
		.clk     (clk),
		.we      (we),
		.waddr   (waddr),
		.wdata   (wdata),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	// load bookkeeping
	assign item_stall = (state_q != hse_pkg::ST_LOAD);
	assign room       = (cnt_q < CW'(DEPTH));
	assign n_next     = room ? cnt_q + CW'(1) : cnt_q;
	assign half       = n_next >> 1;
	assign k_dec      = k_q - CW'(1);

	// sift level: children of the hole and which one wins
	assign left_w  = (CHW'(node_q) << 1) + CHW'(1);
	assign right_w = left_w + CHW'(1);
	assign l_in    = (left_w < CHW'(size_q));
	assign r_in    = (right_w < CHW'(size_q));
	assign rd_l    = $signed(rdata_a);
	assign rd_r    = $signed(rdata_b);
	assign sel_l   = l_in && (rd_l > cur_q);
	assign best    = sel_l ? rd_l : cur_q;
	assign sel_r   = r_in && (rd_r > best);

	// readout: one store read per free output slot
	assign emit_go  = (state_q == hse_pkg::ST_EMIT) && !pend_q && (idx_q != cnt_q) &&
	                  (!res_valid_q || !result_stall);
	assign emit_end = (state_q == hse_pkg::ST_EMIT) && !pend_q && (idx_q == cnt_q);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hse_pkg::ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and store port control
	always_comb begin
		state_d = state_q;
		we      = 1'b0;
		waddr   = cnt_q[AW-1:0];
		wdata   = value;
		raddr_a = left_w[AW-1:0];
		raddr_b = right_w[AW-1:0];
		case (state_q)
			hse_pkg::ST_LOAD: begin
				if (item_valid) begin
					we = room;
					if (last) begin
						state_d = (half != '0) ? hse_pkg::ST_BLD_RD : hse_pkg::ST_EMIT;
					end
				end
			end
			hse_pkg::ST_BLD_RD: begin
				raddr_a = k_dec[AW-1:0];
				state_d = hse_pkg::ST_BLD_LD;
			end
			hse_pkg::ST_BLD_LD: begin
				state_d = hse_pkg::ST_SIFT_RD;
			end
			hse_pkg::ST_SIFT_RD: begin
				state_d = hse_pkg::ST_SIFT_CMP;
			end
			hse_pkg::ST_SIFT_CMP: begin
				we    = 1'b1;
				waddr = node_q;
				if (sel_r) begin
					wdata   = rdata_b;
					state_d = hse_pkg::ST_SIFT_RD;
				end else if (sel_l) begin
					wdata   = rdata_a;
					state_d = hse_pkg::ST_SIFT_RD;
				end else begin
					wdata = cur_q;
					if (bld_q) begin
						state_d = (k_dec != '0) ? hse_pkg::ST_BLD_RD : hse_pkg::ST_EXT_RD;
					end else begin
						state_d = (k_dec > CW'(1)) ? hse_pkg::ST_EXT_RD : hse_pkg::ST_EMIT;
					end
				end
			end
			hse_pkg::ST_EXT_RD: begin
				raddr_a = '0;
				raddr_b = k_dec[AW-1:0];
				state_d = hse_pkg::ST_EXT_LD;
			end
			hse_pkg::ST_EXT_LD: begin
				we      = 1'b1;
				waddr   = k_dec[AW-1:0];
				wdata   = rdata_a;
				state_d = hse_pkg::ST_SIFT_RD;
			end
			hse_pkg::ST_EMIT: begin
				raddr_a = idx_q[AW-1:0];
				if (emit_end) begin
					state_d = hse_pkg::ST_LOAD;
				end
			end
			default: begin
				state_d = hse_pkg::ST_LOAD;
			end
		endcase
	end

	// control counters and sort bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			drop_q      <= 1'b0;
			k_q         <= '0;
			size_q      <= '0;
			node_q      <= '0;
			bld_q       <= 1'b0;
			idx_q       <= '0;
			pend_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			case (state_q)
				hse_pkg::ST_LOAD: begin
					if (item_valid) begin
						cnt_q <= n_next;
						if (!room) begin
							drop_q <= 1'b1;
						end
						if (last) begin
							k_q    <= half;
							size_q <= n_next;
							idx_q  <= '0;
						end
					end
				end
				hse_pkg::ST_BLD_LD: begin
					node_q <= k_dec[AW-1:0];
					bld_q  <= 1'b1;
				end
				hse_pkg::ST_SIFT_CMP: begin
					if (sel_r) begin
						node_q <= right_w[AW-1:0];
					end else if (sel_l) begin
						node_q <= left_w[AW-1:0];
					end else if (bld_q) begin
						k_q <= (k_dec != '0) ? k_dec : cnt_q;
					end else begin
						k_q <= k_dec;
					end
				end
				hse_pkg::ST_EXT_LD: begin
					node_q <= '0;
					size_q <= k_dec;
					bld_q  <= 1'b0;
				end
				hse_pkg::ST_EMIT: begin
					if (emit_go) begin
						idx_q <= idx_q + CW'(1);
					end
					if (emit_end) begin
						cnt_q  <= '0;
						drop_q <= 1'b0;
					end
				end
				default: begin
				end
			endcase

			// output slot: drain on a taken beat, fill when read data lands
			pend_q <= emit_go;
			if (res_valid_q && !result_stall) begin
				res_valid_q <= 1'b0;
			end
			if (pend_q) begin
				res_valid_q <= 1'b1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == hse_pkg::ST_BLD_LD) begin
			cur_q <= $signed(rdata_a);
		end else if (state_q == hse_pkg::ST_EXT_LD) begin
			cur_q <= $signed(rdata_b);
		end
		if (emit_go) begin
			fin_s1 <= ((idx_q + CW'(1)) == cnt_q);
		end
		if (pend_q) begin
			res_value_q <= $signed(rdata_a);
			res_final_q <= fin_s1;
			res_ovf_q   <= drop_q;
		end
	end

	assign result_valid = res_valid_q;
	assign sorted_value = res_value_q;
	assign final_res    = res_final_q;
	assign overflow     = res_ovf_q;

	// checks
	`HSE_CHECK(a_cnt_range, cnt_q <= CW'(DEPTH))
	`HSE_CHECK_IMPL(a_land_slot_free, pend_q, !res_valid_q)
	`HSE_CHECK_IMPL(a_hole_in_heap, state_q == hse_pkg::ST_SIFT_CMP, CW'(node_q) < size_q)
	`HSE_CHECK_IMPL(a_idx_range, state_q == hse_pkg::ST_EMIT, idx_q <= cnt_q)

endmodule

FILE: design/hse_ram.sv
// heap store: one write port, two registered read ports
module hse_ram #(
	parameter int DEPTH = hse_pkg::DEPTH_DEF,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [AW-1:0]             waddr,
	input  logic [hse_pkg::DATA_W-1:0] wdata,
	input  logic [AW-1:0]             raddr_a,
	input  logic [AW-1:0]             raddr_b,
	output logic [hse_pkg::DATA_W-1:0] rdata_a,
	output logic [hse_pkg::DATA_W-1:0] rdata_b
);

	logic [hse_pkg::DATA_W-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read ports, registered
	always_ff @(posedge clk) begin
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule
